### design/tccw_pkg.sv
package tccw_pkg;

    // fixed field widths of the result
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int OFFSET_W     = 11;
    localparam int CELL_W       = 16;
    localparam int BYTE_W       = 8;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

    // command kinds
    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_MOVE,
        MODE_CLEAR,
        MODE_READ
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCROLL,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    // sweep pointer operations
    typedef enum logic [1:0] {
        SW_HOLD,
        SW_LOAD,
        SW_STEP
    } sweep_op_t;

    // address ranges the sweep can cover
    typedef enum logic [1:0] {
        RANGE_ALL,
        RANGE_SCROLL,
        RANGE_LAST_ROW
    } sweep_range_t;

    typedef struct packed {
        sweep_op_t    op;
        sweep_range_t span;
    } sweep_ctrl_t;

endpackage

### design/tccw_ram.sv
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/tccw_sweep.sv
module tccw_sweep import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sweep_ctrl_t       ctrl,
    output logic [ADDR_W-1:0] ptr,
    output logic [ADDR_W-1:0] src,
    output logic              at_end
);

    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int LAST_ROW_FIRST = (ROWS - 1) * COLUMNS;

    localparam logic [ADDR_W-1:0] ALL_LAST    = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(LAST_ROW_FIRST - 1);
    localparam logic [ADDR_W-1:0] ROW_FIRST   = ADDR_W'(LAST_ROW_FIRST);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);

    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;

    // pointer load and step
    always_comb
    begin
        ptr_next = ptr_reg;
        end_next = end_reg;
        case (ctrl.op)
            SW_LOAD:
            begin
                case (ctrl.span)
                    RANGE_SCROLL:
                    begin
                        ptr_next = '0;
                        end_next = SCROLL_LAST;
                    end
                    RANGE_LAST_ROW:
                    begin
                        ptr_next = ROW_FIRST;
                        end_next = ALL_LAST;
                    end
                    default:
                    begin
                        ptr_next = '0;
                        end_next = ALL_LAST;
                    end
                endcase
            end
            SW_STEP:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // reset starts the power-up blanking pass over the whole grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            end_reg <= ALL_LAST;
        end
        else
        begin
            ptr_reg <= ptr_next;
            end_reg <= end_next;
        end
    end

    // source of a scroll copy is one row further down
    assign ptr    = ptr_reg;
    assign src    = ptr_reg + COLS_A;
    assign at_end = (ptr_reg == end_reg);

endmodule

### design/text_console_cell_writer.sv
// Text console cell writer: a grid of ROWS x COLUMNS 16-bit cells (attribute
// in the high byte, character in the low byte) plus a cursor, one command per
// request and one result per command. Commands are handled one at a time and
// every cell access goes through a single-port-write, registered-read RAM, so
// the cost of a command is set by how many cells it touches: a clear blanks
// every cell, and a write or newline that scrolls copies the upper rows one
// row up, drains the last copy, blanks the last row and then gives its
// result. After reset the block blanks the whole grid, one cell per cycle,
// with in_ready low. The result is held in an output register until taken;
// the next request is accepted as soon as the result has been loaded into it.
module text_console_cell_writer import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic [BYTE_W-1:0]       char_code,
    input  logic [BYTE_W-1:0]       attribute,
    input  logic [BYTE_W-1:0]       col,
    input  logic [BYTE_W-1:0]       row,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CURSOR_COL_W-1:0] cursor_col,
    output logic [CURSOR_ROW_W-1:0] cursor_row,
    output logic [OFFSET_W-1:0]     cursor_offset,
    output logic [CELL_W-1:0]       cell_value,
    output logic                    scrolled
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);

    state_t state_reg, state_next;
    logic   fill_init_reg, fill_init_next;
    logic   copy_valid_reg, copy_valid_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;

    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              scroll_reg, scroll_next;

    logic                    out_valid_reg, out_valid_next;
    logic [CURSOR_COL_W-1:0] out_col_reg;
    logic [CURSOR_ROW_W-1:0] out_row_reg;
    logic [OFFSET_W-1:0]     out_off_reg;
    logic [CELL_W-1:0]       out_cell_reg;
    logic                    out_scroll_reg;
    logic                    out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    sweep_ctrl_t       sweep_ctrl;
    logic [ADDR_W-1:0] sweep_ptr;
    logic [ADDR_W-1:0] sweep_src;
    logic              sweep_end;

    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  lin_col;
    logic [ROW_W-1:0]  lin_row;
    logic [ADDR_W-1:0] lin_addr;
    logic [COL_W:0]    col_inc;
    logic              col_wrap;
    logic              accept;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tccw_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sweep_ctrl),
        .ptr    (sweep_ptr),
        .src    (sweep_src),
        .at_end (sweep_end)
    );

    // clamp target coordinates
    assign tgt_col = (col >= BYTE_W'(COLUMNS)) ? COL_LAST : COL_W'(col);
    assign tgt_row = (row >= BYTE_W'(ROWS)) ? ROW_LAST : ROW_W'(row);

    // shared linear address: target for a read request, cursor otherwise
    assign lin_col  = (state_reg == ST_IDLE && mode_t'(mode) == MODE_READ) ? tgt_col
                                                                          : cur_col_reg;
    assign lin_row  = (state_reg == ST_IDLE && mode_t'(mode) == MODE_READ) ? tgt_row
                                                                          : cur_row_reg;
    assign lin_addr = ADDR_W'(lin_row) * COLS_A + ADDR_W'(lin_col);

    // column advance after a character
    assign col_inc  = {1'b0, cur_col_reg} + 1'b1;
    assign col_wrap = (col_inc >= (COL_W + 1)'(COLUMNS));

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // sequencer: next state, cursor update and memory control
    always_comb
    begin
        state_next      = state_reg;
        fill_init_next  = fill_init_reg;
        copy_valid_next = copy_valid_reg;
        copy_addr_next  = copy_addr_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        cell_next       = cell_reg;
        scroll_next     = scroll_reg;
        ram_we          = 1'b0;
        ram_waddr       = sweep_ptr;
        ram_wdata       = BLANK_CELL;
        ram_raddr       = sweep_src;
        sweep_ctrl.op   = SW_HOLD;
        sweep_ctrl.span = RANGE_ALL;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_next   = '0;
                    scroll_next = 1'b0;
                    state_next  = ST_DONE;
                    case (mode_t'(mode))
                        MODE_WRITE:
                        begin
                            if (char_code != NEWLINE_CODE)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = lin_addr;
                                ram_wdata    = {attribute, char_code};
                                cur_col_next = col_inc[COL_W-1:0];
                            end
                            // newline, or wrap past the last column
                            if (char_code == NEWLINE_CODE || col_wrap)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_LAST)
                                begin
                                    scroll_next     = 1'b1;
                                    copy_valid_next = 1'b0;
                                    sweep_ctrl.op   = SW_LOAD;
                                    sweep_ctrl.span = RANGE_SCROLL;
                                    state_next      = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                        end
                        MODE_MOVE:
                        begin
                            cur_col_next = tgt_col;
                            cur_row_next = tgt_row;
                        end
                        MODE_CLEAR:
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = '0;
                            fill_init_next  = 1'b0;
                            sweep_ctrl.op   = SW_LOAD;
                            sweep_ctrl.span = RANGE_ALL;
                            state_next      = ST_FILL;
                        end
                        default:
                        begin
                            ram_raddr  = lin_addr;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                // read one row down, write the cell read last cycle
                ram_raddr       = sweep_src;
                ram_we          = copy_valid_reg;
                ram_waddr       = copy_addr_reg;
                ram_wdata       = ram_rdata;
                copy_valid_next = 1'b1;
                copy_addr_next  = sweep_ptr;
                sweep_ctrl.op   = SW_STEP;
                if (sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                ram_we          = 1'b1;
                ram_waddr       = copy_addr_reg;
                ram_wdata       = ram_rdata;
                copy_valid_next = 1'b0;
                fill_init_next  = 1'b0;
                sweep_ctrl.op   = SW_LOAD;
                sweep_ctrl.span = RANGE_LAST_ROW;
                state_next      = ST_FILL;
            end
            ST_FILL:
            begin
                ram_we        = 1'b1;
                ram_waddr     = sweep_ptr;
                ram_wdata     = BLANK_CELL;
                sweep_ctrl.op = SW_STEP;
                if (sweep_end)
                begin
                    fill_init_next = 1'b0;
                    state_next     = fill_init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            fill_init_reg  <= 1'b1;
            copy_valid_reg <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_init_reg  <= fill_init_next;
            copy_valid_reg <= copy_valid_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        cell_reg      <= cell_next;
        scroll_reg    <= scroll_next;
        if (out_load)
        begin
            out_col_reg    <= CURSOR_COL_W'(cur_col_reg);
            out_row_reg    <= CURSOR_ROW_W'(cur_row_reg);
            out_off_reg    <= OFFSET_W'(lin_addr);
            out_cell_reg   <= cell_reg;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_col    = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_offset = out_off_reg;
    assign cell_value    = out_cell_reg;
    assign scrolled      = out_scroll_reg;

endmodule

### design/tccw_checker.sv
module tccw_checker import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [1:0]              mode,
    input logic [BYTE_W-1:0]       char_code,
    input logic [BYTE_W-1:0]       attribute,
    input logic [BYTE_W-1:0]       col,
    input logic [BYTE_W-1:0]       row,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [CURSOR_COL_W-1:0] cursor_col,
    input logic [CURSOR_ROW_W-1:0] cursor_row,
    input logic [OFFSET_W-1:0]     cursor_offset,
    input logic [CELL_W-1:0]       cell_value,
    input logic                    scrolled
);

    logic last_read_reg;
    logic shown_read_reg;
    logic prev_valid_reg;
    logic prev_ready_reg;
    logic out_loaded;
    logic shown_read;

    // remember whether the last accepted request was a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_read_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            last_read_reg <= (mode_t'(mode) == MODE_READ);
        end
    end

    // a fresh result sits in the output register this cycle
    assign out_loaded = out_valid && (!prev_valid_reg || prev_ready_reg);
    assign shown_read = out_loaded ? last_read_reg : shown_read_reg;

    // track which request the output register holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_ready_reg <= 1'b0;
            shown_read_reg <= 1'b0;
        end
        else
        begin
            prev_valid_reg <= out_valid;
            prev_ready_reg <= out_ready;
            shown_read_reg <= shown_read;
        end
    end

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_offset)
            && $stable(cell_value) && $stable(scrolled))
        else $error("stalled result changed");

    // an accepted request drops in_ready in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted on back-to-back cycles");

    // only a read returns cell contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !shown_read |-> cell_value == '0)
        else $error("cell value on a non-read command");

    // a scroll leaves the cursor at the start of the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_col == '0
            && cursor_row == CURSOR_ROW_W'(ROWS - 1))
        else $error("scroll left cursor off the last row start");

    // cursor column stays inside the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(cursor_col) < COLUMNS)
        else $error("cursor column out of range");

endmodule

bind text_console_cell_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tccw_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS_N       = 25;
    localparam int CELLS        = COLS * ROWS_N;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_WAIT   = 40;
    localparam int LIMIT_CYCLES = 6_000_000;

    typedef struct packed {
        logic [CURSOR_COL_W-1:0] col;
        logic [CURSOR_ROW_W-1:0] row;
        logic [OFFSET_W-1:0]     offset;
        logic [CELL_W-1:0]       cell_data;
        logic                    scr;
    } console_result_t;

    typedef struct packed {
        mode_t           m;
        logic [7:0]      ch;
        logic [7:0]      attr;
        logic [7:0]      c;
        logic [7:0]      r;
        logic            typed;
        console_result_t want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              mode;
    logic [BYTE_W-1:0]       char_code;
    logic [BYTE_W-1:0]       attribute;
    logic [BYTE_W-1:0]       col;
    logic [BYTE_W-1:0]       row;
    logic                    out_valid;
    logic                    out_ready;
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [OFFSET_W-1:0]     cursor_offset;
    logic [CELL_W-1:0]       cell_value;
    logic                    scrolled;

    // predictor state: grid contents and cursor
    logic [CELL_W-1:0] screen_mem [0:CELLS-1];
    int unsigned       cursor_c;
    int unsigned       cursor_r;

    console_result_t results_pending [$];

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_off_armed;
    bit hold_off_done;
    int commands_sent;
    int results_checked;
    int scrolls_seen;
    int clears_sent;
    int mismatch_count;
    int cycle_count;

    // directed table; typed expectations only where obvious
    stim_row_t directed_rows [0:23] = '{
        '{MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0F20, 1'b0}},
        '{MODE_READ,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0F20, 1'b0}},
        '{MODE_WRITE, 8'h41, 8'h1E, 8'h00, 8'h00, 1'b1, '{7'd1,  5'd0,  11'd1,    16'h0000, 1'b0}},
        '{MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{7'd2,  5'd0,  11'd2,    16'h0000, 1'b0}},
        '{MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{7'd2,  5'd0,  11'd2,    16'h1E41, 1'b0}},
        '{MODE_READ,  8'h00, 8'h00, 8'h01, 8'h00, 1'b1, '{7'd2,  5'd0,  11'd2,    16'hFFFF, 1'b0}},
        '{MODE_WRITE, 8'h0A, 8'h77, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd1,  11'd80,   16'h0000, 1'b0}},
        '{MODE_WRITE, 8'h80, 8'h55, 8'h00, 8'h00, 1'b1, '{7'd1,  5'd1,  11'd81,   16'h0000, 1'b0}},
        '{MODE_READ,  8'h00, 8'h00, 8'h00, 8'h01, 1'b1, '{7'd1,  5'd1,  11'd81,   16'h5580, 1'b0}},
        '{MODE_MOVE,  8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b0}},
        '{MODE_WRITE, 8'h5A, 8'h2F, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd24, 11'd1920, 16'h0000, 1'b1}},
        '{MODE_READ,  8'h00, 8'h00, 8'd79, 8'd23, 1'b0, '0},
        '{MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{MODE_MOVE,  8'h00, 8'h00, 8'd79, 8'd0,  1'b1, '{7'd79, 5'd0,  11'd79,   16'h0000, 1'b0}},
        '{MODE_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd1,  11'd80,   16'h0000, 1'b0}},
        '{MODE_MOVE,  8'h00, 8'h00, 8'd0,  8'd24, 1'b1, '{7'd0,  5'd24, 11'd1920, 16'h0000, 1'b0}},
        '{MODE_WRITE, 8'h0A, 8'h00, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd24, 11'd1920, 16'h0000, 1'b1}},
        '{MODE_READ,  8'h00, 8'h00, 8'd79, 8'd23, 1'b0, '0},
        '{MODE_MOVE,  8'h00, 8'h00, 8'd80, 8'd25, 1'b1, '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b0}},
        '{MODE_MOVE,  8'h00, 8'h00, 8'hAA, 8'h55, 1'b1, '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b0}},
        '{MODE_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0000, 1'b0}},
        '{MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{7'd0,  5'd0,  11'd0,    16'h0F20, 1'b0}},
        '{MODE_MOVE,  8'h00, 8'h00, 8'd79, 8'd24, 1'b1, '{7'd79, 5'd24, 11'd1999, 16'h0000, 1'b0}},
        '{MODE_READ,  8'h00, 8'h00, 8'd79, 8'd24, 1'b0, '0}
    };

    text_console_cell_writer #(
        .COLUMNS (COLS),
        .ROWS    (ROWS_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .char_code     (char_code),
        .attribute     (attribute),
        .col           (col),
        .row           (row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .scrolled      (scrolled)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // cursor to start of next line, scrolling on the last row
    function automatic logic advance_line();
        int unsigned i;
        cursor_c = 0;
        if (cursor_r + 1 >= ROWS_N)
        begin
            for (i = 0; i < (ROWS_N - 1) * COLS; i++)
                screen_mem[i] = screen_mem[i + COLS];
            for (i = (ROWS_N - 1) * COLS; i < CELLS; i++)
                screen_mem[i] = BLANK_CELL;
            cursor_r = ROWS_N - 1;
            return 1'b1;
        end
        cursor_r++;
        return 1'b0;
    endfunction

    // apply one request to the predicted console and return its result
    function automatic console_result_t apply_command(mode_t m, logic [7:0] ch,
                                                      logic [7:0] attr, logic [7:0] c,
                                                      logic [7:0] r);
        console_result_t res;
        int unsigned     tc;
        int unsigned     tr;
        int unsigned     i;
        res = '0;
        tc = (c >= COLS) ? COLS - 1 : c;
        tr = (r >= ROWS_N) ? ROWS_N - 1 : r;
        case (m)
            MODE_WRITE:
            begin
                if (ch == NEWLINE_CODE)
                    res.scr = advance_line();
                else
                begin
                    screen_mem[cursor_r * COLS + cursor_c] = {attr, ch};
                    cursor_c++;
                    if (cursor_c >= COLS)
                        res.scr = advance_line();
                end
            end
            MODE_MOVE:
            begin
                cursor_c = tc;
                cursor_r = tr;
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_mem[i] = BLANK_CELL;
                cursor_c = 0;
                cursor_r = 0;
            end
            default:
                res.cell_data = screen_mem[tr * COLS + tc];
        endcase
        res.col    = cursor_c[CURSOR_COL_W-1:0];
        res.row    = cursor_r[CURSOR_ROW_W-1:0];
        res.offset = OFFSET_W'(cursor_r * COLS + cursor_c);
        return res;
    endfunction

    // offer one request, wait for acceptance, record its expectation
    task automatic send_command(input mode_t m, input logic [7:0] ch, input logic [7:0] attr,
                                input logic [7:0] c, input logic [7:0] r, input logic typed,
                                input console_result_t want);
        console_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        char_code <= ch;
        attribute <= attr;
        col       <= c;
        row       <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_command(m, ch, attr, c, r);
        results_pending.push_back(typed ? want : predicted);
        commands_sent++;
        if (m == MODE_CLEAR)
            clears_sent++;
        @(negedge clk);
    endtask

    // random request: mostly text with line breaks, cursor moves (half near the bottom), reads, rare clears
    task automatic random_command();
        mode_t      m;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [7:0] c;
        logic [7:0] r;
        int         pick;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        attr = 8'($urandom_range(255));
        c    = 8'($urandom_range(255));
        r    = 8'($urandom_range(255));
        if (pick < 55)
        begin
            m = MODE_WRITE;
            if ($urandom_range(99) < 80)
                ch = 8'($urandom_range(8'h7E, 8'h20));
        end
        else if (pick < 67)
        begin
            m  = MODE_WRITE;
            ch = NEWLINE_CODE;
        end
        else if (pick < 80)
        begin
            m = MODE_MOVE;
            if ($urandom_range(1))
            begin
                c = 8'($urandom_range(COLS - 1, COLS - 12));
                r = 8'($urandom_range(ROWS_N - 1, ROWS_N - 4));
            end
        end
        else if (pick < 98)
        begin
            m = MODE_READ;
            if ($urandom_range(1))
            begin
                c = 8'($urandom_range(COLS - 1));
                r = 8'($urandom_range(ROWS_N - 1));
            end
        end
        else
            m = MODE_CLEAR;
        send_command(m, ch, attr, c, r, 1'b0, '0);
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF - 1)
                    @(negedge clk);
                hold_off_done = 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check each taken result against the oldest expectation
    always @(posedge clk)
    begin
        console_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_pending.size() == 0)
            begin
                $error("result with nothing expected: col %0d row %0d", cursor_col,
                       cursor_row);
                mismatch_count++;
            end
            else
            begin
                exp_res = results_pending.pop_front();
                results_checked++;
                if (scrolled)
                    scrolls_seen++;
                if (cursor_col !== exp_res.col)
                begin
                    $error("cursor_col: expected %0d, got %0d", exp_res.col, cursor_col);
                    mismatch_count++;
                end
                if (cursor_row !== exp_res.row)
                begin
                    $error("cursor_row: expected %0d, got %0d", exp_res.row, cursor_row);
                    mismatch_count++;
                end
                if (cursor_offset !== exp_res.offset)
                begin
                    $error("cursor_offset: expected %0d, got %0d", exp_res.offset,
                           cursor_offset);
                    mismatch_count++;
                end
                if (cell_value !== exp_res.cell_data)
                begin
                    $error("cell_value: expected %h, got %h", exp_res.cell_data, cell_value);
                    mismatch_count++;
                end
                if (scrolled !== exp_res.scr)
                begin
                    $error("scrolled: expected %0d, got %0d", exp_res.scr, scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // reset, directed table, random phases, drain
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_WRITE;
        char_code       = '0;
        attribute       = '0;
        col             = '0;
        row             = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_off_armed  = 1'b0;
        commands_sent   = 0;
        results_checked = 0;
        scrolls_seen    = 0;
        clears_sent     = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = BLANK_CELL;
        cursor_c = 0;
        cursor_r = 0;

        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].m, directed_rows[i].ch, directed_rows[i].attr,
                         directed_rows[i].c, directed_rows[i].r, directed_rows[i].typed,
                         directed_rows[i].want);

        // four idling phases; the first one starts with the long hold-off
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    hold_off_armed  = 1'b1;
                end
                1:
                begin
                    sender_idle_pct = 85;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 85;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    recv_stall_pct  = 33;
                end
            endcase
            repeat (RANDOM_ITEMS / 4)
                random_command();
        end
        in_valid <= 1'b0;

        while (results_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("tb_top: %0d requests sent, %0d results checked over four idling phases",
                 commands_sent, results_checked);
        $display("tb_top: %0d scrolls and %0d clears exercised, plus a %0d-cycle output stall",
                 scrolls_seen, clears_sent, HOLD_OFF);
        if (mismatch_count == 0 && results_pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
